// ----- sv/wso_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wso_pkg
// Constants, phase-step reciprocal and quarter-wave sine table for the
// wavetable sine oscillator.
// ----------------------------------------------------------------------------
package wso_pkg;

    localparam int TABLE_SIZE          = 1024;
    localparam int PHASE_FRACTION_BITS = 16;
    localparam int SAMPLE_RATE         = 48000;

    localparam int TABLE_BITS   = $clog2(TABLE_SIZE);
    localparam int PHASE_BITS   = TABLE_BITS + PHASE_FRACTION_BITS;
    localparam int QUARTER_BITS = TABLE_BITS - 2;
    localparam int QUARTER_SIZE = TABLE_SIZE / 4;

    localparam int FREQ_W   = 15;
    localparam int SAMPLE_W = 16;
    localparam int SINE_W   = SAMPLE_W - 1;

    localparam int MAX_FREQ   = 20000;
    localparam int MID_LEVEL  = 32768;
    localparam int PEAK_LEVEL = 32767;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // step = floor(f * 2^PHASE_BITS / SAMPLE_RATE) done as (f * M) >> STEP_SHIFT,
    // M rounded up; exact for f * SAMPLE_RATE < 2^STEP_SHIFT
    localparam int STEP_SHIFT = $clog2(MAX_FREQ * 64'(SAMPLE_RATE) + 64'd1);
    localparam logic [127:0] STEP_NUM  = 128'd1 << (PHASE_BITS + STEP_SHIFT);
    localparam logic [127:0] STEP_MULT =
        (STEP_NUM + 128'(SAMPLE_RATE - 1)) / 128'(SAMPLE_RATE);
    localparam int MULT_W = $clog2(STEP_MULT + 128'd1);
    localparam int PROD_W = PHASE_BITS + STEP_SHIFT + 2;

    typedef logic [SINE_W-1:0] quarter_rom_t [QUARTER_SIZE];

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    // floor(32767 * sin((pi/2) * m / QUARTER_SIZE)), Q62 Taylor series
    function automatic logic [63:0] scaled_sine(input logic [63:0] m);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] a;
        logic [63:0] b;
        x = (HALF_PI_Q62 / 64'(QUARTER_SIZE)) * m
            + ((HALF_PI_Q62 % 64'(QUARTER_SIZE)) * m) / 64'(QUARTER_SIZE);
        x2   = q62_mul(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= 16; k++)
        begin
            term = q62_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        a = 64'(PEAK_LEVEL) * (sum >> 32);
        b = 64'(PEAK_LEVEL) * {32'd0, sum[31:0]};
        return (a + (b >> 32)) >> 30;
    endfunction

    // entry 0 is never read: angle zero is handled outside the table
    function automatic quarter_rom_t build_quarter_rom();
        quarter_rom_t rom;
        rom[0] = '0;
        for (int m = 1; m < QUARTER_SIZE; m++)
        begin
            rom[m] = SINE_W'(scaled_sine(64'(m)));
        end
        return rom;
    endfunction

    localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();

endpackage

// ----- sv/wavetable_sine_oscillator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_sine_oscillator_core
// Direct digital synthesis sine source: one stereo frame per tone word.
// ----------------------------------------------------------------------------
// Takes one tone word (frequency in Hz, saturated at 20 kHz) per cycle and
// returns one stereo frame per word: the first register holds the phase
// step (one constant multiply), the second the sample read from a
// quarter-wave table at the current phase while the phase accumulator
// advances. Sustained rate is one word per cycle while frame_stall is low;
// the phase accumulator loop sets it. Frequency 0 gives mid-level and holds
// the phase. double_step (reset 1) advances the phase by two steps per frame.
// ----------------------------------------------------------------------------
module wavetable_sine_oscillator_core
    import wso_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tone_valid,
    output logic                tone_stall,
    input  logic [FREQ_W-1:0]   tone_frequency,
    output logic                frame_valid,
    input  logic                frame_stall,
    output logic [SAMPLE_W-1:0] left_sample,
    output logic [SAMPLE_W-1:0] right_sample,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                double_step
);

    logic                  double_step_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic                  step_valid_reg;
    logic [PHASE_BITS-1:0] step_reg;
    logic                  silent_reg;
    logic                  frame_valid_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SAMPLE_W-1:0]   sample_next;

    logic                  out_en;
    logic                  step_en;
    logic                  advance;
    logic [FREQ_W-1:0]     freq_sat;
    logic [PROD_W-1:0]     step_prod;
    logic [PHASE_BITS-1:0] phase_advance;

    logic [TABLE_BITS-1:0]   table_idx;
    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] quad_pos;
    logic [QUARTER_BITS:0]   mirror;
    logic [SINE_W-1:0]       sine_mag;

    assign cfg_ready = 1'b1;

    // output stage moves when empty or taken; step stage when it can drain
    assign out_en     = !frame_valid_reg || !frame_stall;
    assign step_en    = !step_valid_reg || out_en;
    assign tone_stall = !step_en;
    assign advance    = step_valid_reg && out_en;

    assign freq_sat  = (tone_frequency > FREQ_W'(MAX_FREQ)) ? FREQ_W'(MAX_FREQ)
                                                             : tone_frequency;
    assign step_prod = PROD_W'(freq_sat) * PROD_W'(STEP_MULT[MULT_W-1:0]);

    assign phase_advance = double_step_reg ? {step_reg[PHASE_BITS-2:0], 1'b0} : step_reg;

    always_comb
    begin
        phase_next = phase_reg;
        if (advance && !silent_reg)
        begin
            phase_next = phase_reg + phase_advance;
        end
    end

    // quarter-wave lookup: fold the index onto the first quadrant
    assign table_idx = phase_reg[PHASE_BITS-1 -: TABLE_BITS];
    assign quad      = table_idx[TABLE_BITS-1 -: 2];
    assign quad_pos  = table_idx[QUARTER_BITS-1:0];
    assign mirror    = quad[0] ? ((QUARTER_BITS+1)'(QUARTER_SIZE) - {1'b0, quad_pos})
                               : {1'b0, quad_pos};
    assign sine_mag  = QUARTER_ROM[mirror[QUARTER_BITS-1:0]];

    always_comb
    begin
        if (silent_reg || (mirror == '0))
        begin
            sample_next = SAMPLE_W'(MID_LEVEL);
        end
        else if (mirror[QUARTER_BITS])
        begin
            sample_next = quad[1] ? SAMPLE_W'(MID_LEVEL - PEAK_LEVEL)
                                  : SAMPLE_W'(MID_LEVEL + PEAK_LEVEL);
        end
        else if (quad[1])
        begin
            sample_next = SAMPLE_W'(MID_LEVEL - 1) - SAMPLE_W'(sine_mag);
        end
        else
        begin
            sample_next = SAMPLE_W'(MID_LEVEL) + SAMPLE_W'(sine_mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            double_step_reg <= 1'b1;
            phase_reg       <= '0;
            step_valid_reg  <= 1'b0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                double_step_reg <= double_step;
            end
            phase_reg <= phase_next;
            if (step_en)
            begin
                step_valid_reg <= tone_valid;
            end
            if (out_en)
            begin
                frame_valid_reg <= step_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && tone_valid)
        begin
            step_reg   <= step_prod[STEP_SHIFT +: PHASE_BITS];
            silent_reg <= (tone_frequency == '0);
        end
        if (advance)
        begin
            sample_reg <= sample_next;
        end
    end

    assign frame_valid  = frame_valid_reg;
    assign left_sample  = sample_reg;
    assign right_sample = sample_reg;

    // a stalled input always means the step stage holds a word
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        tone_stall |-> step_valid_reg)
        else $error("tone_stall with empty step stage");

    a_silence_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && silent_reg) |=> (phase_reg == $past(phase_reg)))
        else $error("phase moved on a silent word");

    a_silence_mid_level: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && silent_reg) |=> (left_sample == SAMPLE_W'(MID_LEVEL)))
        else $error("silent word gave a non mid-level sample");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && !frame_stall && !step_valid_reg) |=> !frame_valid)
        else $error("frame repeated after being taken");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wavetable sine oscillator core.
// ----------------------------------------------------------------------------
// Tone words go in and stereo frames are checked against a bench-side
// oscillator model. That model has its own full-wave sine table, phase
// accumulator and double-step setting. Tone words get random idle gaps and
// frames random stall bursts. The double-step register is rewritten between
// phases while the core is idle. The last phase runs with no throttling.
// ----------------------------------------------------------------------------
module tb_top
    import wso_pkg::*;
();

    // tracks the oscillator and holds the frames still owed by the core
    class frame_scoreboard;
        logic [SAMPLE_W-1:0]   sine_table [TABLE_SIZE];
        logic [PHASE_BITS-1:0] phase;
        bit                    doubled;
        logic [SAMPLE_W-1:0]   due [$];
        int                    errors;

        function new();
            phase   = '0;
            doubled = 1'b1;
            errors  = 0;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                sine_table[i] = table_entry(i);
            end
        endfunction

        function longint unsigned fix_mul(longint unsigned a, longint unsigned b);
            logic [127:0] wide;
            wide = {64'd0, a} * {64'd0, b};
            return wide[125:62];
        endfunction

        // floor(32767 * sin(pi/2 * m / n)), Q62 Taylor series
        function longint unsigned sine_scaled(longint unsigned m, longint unsigned n);
            longint unsigned ang;
            longint unsigned ang_sq;
            longint unsigned term;
            longint unsigned acc;
            longint unsigned hi_part;
            longint unsigned lo_part;
            ang    = (HALF_PI_Q62 / n) * m + ((HALF_PI_Q62 % n) * m) / n;
            ang_sq = fix_mul(ang, ang);
            term   = ang;
            acc    = ang;
            for (int k = 1; k <= 16; k++)
            begin
                term = fix_mul(term, ang_sq) / 64'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1)
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
            hi_part = 64'(PEAK_LEVEL) * (acc >> 32);
            lo_part = 64'(PEAK_LEVEL) * (acc & 64'hFFFF_FFFF);
            return (hi_part + (lo_part >> 32)) >> 30;
        endfunction

        function logic [SAMPLE_W-1:0] table_entry(int i);
            longint unsigned n;
            longint unsigned quad;
            longint unsigned rem;
            longint unsigned m;
            longint unsigned s;
            n    = TABLE_SIZE;
            quad = (4 * i) / n;
            rem  = (4 * i) % n;
            m    = quad[0] ? n - rem : rem;
            if (m == 0)
            begin
                return SAMPLE_W'(MID_LEVEL);
            end
            if (m == n)
            begin
                return (quad >= 2) ? SAMPLE_W'(MID_LEVEL - PEAK_LEVEL)
                                   : SAMPLE_W'(MID_LEVEL + PEAK_LEVEL);
            end
            s = sine_scaled(m, n);
            // lower half: true value never an integer, so floor drops one more
            return (quad >= 2) ? SAMPLE_W'(MID_LEVEL - s - 1) : SAMPLE_W'(MID_LEVEL + s);
        endfunction

        function void set_double_step(bit v);
            doubled = v;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_tone(logic [FREQ_W-1:0] f);
            int unsigned           hz;
            logic [63:0]           num;
            logic [PHASE_BITS-1:0] stride;
            hz = (f > MAX_FREQ) ? MAX_FREQ : f;
            if (hz == 0)
            begin
                // silence: mid level, phase held
                due.push_back(SAMPLE_W'(MID_LEVEL));
                return;
            end
            num    = (64'(hz) * 64'(TABLE_SIZE)) << PHASE_FRACTION_BITS;
            stride = PHASE_BITS'(num / 64'(SAMPLE_RATE));
            due.push_back(sine_table[phase >> PHASE_FRACTION_BITS]);
            // accumulator width gives the wrap
            phase = phase + (doubled ? PHASE_BITS'(stride << 1) : stride);
        endfunction

        function void check_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
            logic [SAMPLE_W-1:0] want;
            if (due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected frame, expected none, actual left %0d right %0d",
                         $time, l, r);
                return;
            end
            want = due.pop_front();
            if (l !== want)
            begin
                errors++;
                $display("%0t: left_sample expected %0d actual %0d", $time, want, l);
            end
            if (r !== want)
            begin
                errors++;
                $display("%0t: right_sample expected %0d actual %0d", $time, want, r);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                tone_valid = 1'b0;
    logic                tone_stall;
    logic [FREQ_W-1:0]   tone_frequency = '0;
    logic                frame_valid;
    logic                frame_stall = 1'b0;
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] right_sample;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                double_step = 1'b1;

    frame_scoreboard board;
    int              send_idle_odds = 0;
    int              recv_idle_odds = 0;
    int              stall_left = 0;

    localparam int OPENING_TONES [20] = '{0, 12000, 12000, 12000, 0, 12000, 1, 2,
                                          20000, 20001, 32767, 16384, 24000, 8191,
                                          10922, 21845, 440, 0, 47, 19999};

    wavetable_sine_oscillator_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .tone_valid     (tone_valid),
        .tone_stall     (tone_stall),
        .tone_frequency (tone_frequency),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .double_step    (double_step)
    );

    always #6 clk = ~clk;

    // frame side back-pressure in bursts; a burst ends as soon as throttling is off
    always @(negedge clk)
    begin
        if (recv_idle_odds == 0)
        begin
            stall_left  <= 0;
            frame_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left  <= stall_left - 1;
            frame_stall <= 1'b1;
        end
        else if ($urandom_range(recv_idle_odds - 1) == 0)
        begin
            stall_left  <= $urandom_range(13);
            frame_stall <= 1'b1;
        end
        else
        begin
            frame_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && frame_valid && !frame_stall)
        begin
            board.check_frame(left_sample, right_sample);
        end
    end

    function automatic int pick_odds();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 2;
            2:       return 5;
            default: return 10;
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] pick_tone();
        case ($urandom_range(9))
            0:       return '0;
            1:       return FREQ_W'($urandom_range(32767, 20001));
            2:       return FREQ_W'($urandom);
            3:       return FREQ_W'($urandom_range(100, 1));
            4:       return FREQ_W'(375 * $urandom_range(53, 1)); // whole table steps
            default: return FREQ_W'($urandom_range(20000));
        endcase
    endfunction

    task automatic send_tone(input logic [FREQ_W-1:0] f);
        @(negedge clk);
        tone_valid     <= 1'b1;
        tone_frequency <= f;
        do
            @(posedge clk);
        while (tone_stall);
        board.note_tone(f);
    endtask

    task automatic offer_tone(input logic [FREQ_W-1:0] f);
        int gap;
        if (send_idle_odds != 0 && $urandom_range(send_idle_odds - 1) == 0)
        begin
            gap = $urandom_range(14, 1);
            @(negedge clk);
            tone_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        send_tone(f);
    endtask

    // drain the core before touching the register
    task automatic settle();
        @(negedge clk);
        tone_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_double_step(input bit v);
        settle();
        @(negedge clk);
        cfg_valid   <= 1'b1;
        double_step <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_double_step(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit bursts);
        int                sent;
        int                hold;
        logic [FREQ_W-1:0] f;
        sent = 0;
        while (sent < count)
        begin
            f    = pick_tone();
            // held notes as well as single words
            hold = ($urandom_range(3) == 0) ? $urandom_range(16, 1) : 1;
            repeat (hold)
            begin
                if (sent % 64 == 0)
                begin
                    send_idle_odds = bursts ? pick_odds() : 0;
                    recv_idle_odds = bursts ? pick_odds() : 0;
                end
                offer_tone(f);
                sent++;
            end
        end
    endtask

    initial
    begin
        int waited;
        board = new();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        write_double_step(1'b1);
        send_idle_odds = 4;
        recv_idle_odds = 4;
        foreach (OPENING_TONES[i])
        begin
            offer_tone(FREQ_W'(OPENING_TONES[i]));
        end
        write_double_step(1'b0);
        repeat (5) offer_tone(FREQ_W'(12000));

        run_random(700, 1'b1);
        write_double_step(1'b1);
        run_random(700, 1'b1);
        write_double_step(1'b0);
        run_random(300, 1'b1);
        write_double_step(1'b1);
        run_random(300, 1'b0);

        @(negedge clk);
        tone_valid <= 1'b0;
        waited = 0;
        while (board.pending() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            if (board.pending() != 0)
            begin
                $display("%0t: %0d frames never arrived", $time, board.pending());
            end
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
